### design/column_mean_range_scaler_top_assert.svh
// assertion macros for the column mean range scaler
`ifndef COLUMN_MEAN_RANGE_SCALER_TOP_ASSERT_SVH
`define COLUMN_MEAN_RANGE_SCALER_TOP_ASSERT_SVH
// implication checked on every clock edge outside reset
`define CMRS_ASSERT_IMP(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
// next-cycle implication checked outside reset
`define CMRS_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`endif

### design/cmrs_pkg.sv
// shared types, constants and state encoding for the column mean range scaler
package cmrs_pkg;
    localparam int MAX_ROWS_DEF = 256;
    localparam int MAX_COLS_DEF = 16;
    localparam int ROW_W = 8;
    localparam int COL_W = 4;
    localparam int SUM_W = 40;
    localparam int CNT_W = 9;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_LOAD  = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_ZERO = 2'd1,
        ST_SAT  = 2'd2
    } t_status;

    localparam logic [31:0] MISSING_MARK = 32'hFFFF_0000;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [ROW_W-1:0]  row_index;
        logic [COL_W-1:0]  col_index;
        logic signed [31:0] value;
    } t_in;

    typedef struct packed {
        logic signed [31:0] scaled_value;
        logic [1:0]         status;
    } t_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_DIV1,
        S_PREP2,
        S_DIV2,
        S_DONE,
        S_OUT
    } t_state;

    typedef struct packed {
        logic capture;
        logic fetch;
        logic div_start;
        logic prep2;
        logic finish;
    } t_ctrl;

    typedef struct packed {
        logic is_read;
        logic div_done;
        logic skip_div;
    } t_stat;
endpackage

### design/cmrs_div.sv
// radix-2 restoring divider for signed operands, quotient truncated toward zero
module cmrs_div import cmrs_pkg::*; #(
    parameter int W = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic signed [W-1:0] i_num,
    input  logic signed [W-1:0] i_den,
    output logic                o_done,
    output logic signed [W-1:0] o_quot
);
    localparam int CW = $clog2(W + 1);
    logic [W-1:0]  r_q, n_q;
    logic [W:0]    r_rem, n_rem;
    logic [W-1:0]  r_den, n_den;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_busy, n_busy, r_neg, n_neg, r_done, n_done;
    logic [W:0]    w_sh, w_sub;

    always_comb begin
        n_q = r_q; n_rem = r_rem; n_den = r_den; n_cnt = r_cnt;
        n_busy = r_busy; n_neg = r_neg; n_done = 1'b0;
        w_sh = {r_rem[W-1:0], r_q[W-1]};
        w_sub = w_sh - {1'b0, r_den};
        if (i_start) begin
            n_q = i_num[W-1] ? W'(-i_num) : i_num;
            n_den = i_den[W-1] ? W'(-i_den) : i_den;
            n_rem = '0;
            n_neg = i_num[W-1] ^ i_den[W-1];
            n_cnt = CW'(W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (!w_sub[W]) begin
                n_rem = w_sub;
                n_q = {r_q[W-2:0], 1'b1};
            end else begin
                n_rem = w_sh;
                n_q = {r_q[W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt <= n_cnt;
        end
        r_q <= n_q; r_rem <= n_rem; r_den <= n_den; r_neg <= n_neg;
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? W'(-r_q) : r_q;
endmodule

### design/cmrs_ctrl.sv
// controller state machine sequencing loads and the two divisions of a read
module cmrs_ctrl import cmrs_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_in_valid,
    output logic   o_in_ready,
    output logic   o_out_valid,
    input  logic   i_out_ready,
    input  t_stat  i_stat,
    output t_ctrl  o_ctrl
);
    `include "column_mean_range_scaler_top_assert.svh"
    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_FETCH;
            S_FETCH: n_state = !i_stat.is_read ? S_IDLE :
                               (i_stat.skip_div ? S_DONE : S_DIV1);
            S_DIV1:  if (i_stat.div_done) n_state = S_PREP2;
            S_PREP2: n_state = S_DIV2;
            S_DIV2:  if (i_stat.div_done) n_state = S_DONE;
            S_DONE:  n_state = S_OUT;
            S_OUT:   if (i_out_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ctrl = '0;
        o_in_ready = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_ctrl.capture = i_in_valid;
            end
            S_FETCH: begin
                o_ctrl.fetch = 1'b1;
                o_ctrl.div_start = i_stat.is_read && !i_stat.skip_div;
            end
            S_PREP2: begin
                o_ctrl.prep2 = 1'b1;
                o_ctrl.div_start = 1'b1;
            end
            S_DONE:  o_ctrl.finish = 1'b1;
            S_OUT:   o_out_valid = 1'b1;
            default: o_ctrl = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end

    `CMRS_ASSERT_IMP(a_excl, i_clk, i_rst_n, o_in_ready, !o_out_valid)
    `CMRS_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)
    `CMRS_ASSERT_NEXT(a_cap, i_clk, i_rst_n, o_in_ready && i_in_valid, r_state == S_FETCH)
endmodule

### design/cmrs_dp.sv
// datapath: element memory, column statistics, mean and scaling arithmetic
module cmrs_dp import cmrs_pkg::*; #(
    parameter int MAX_ROWS = MAX_ROWS_DEF,
    parameter int MAX_COLS = MAX_COLS_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_in   i_in,
    input  t_ctrl i_ctrl,
    output t_stat o_stat,
    output t_out  o_out
);
    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CIW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int DW = 64;

    logic signed [31:0]    r_mem [DEPTH];
    logic signed [SUM_W-1:0] r_sum [MAX_COLS];
    logic [CNT_W-1:0]      r_cnt [MAX_COLS];
    logic signed [31:0]    r_min [MAX_COLS];
    logic signed [31:0]    r_max [MAX_COLS];

    t_in  r_in;
    logic r_inside;
    logic signed [31:0] r_elem;
    logic signed [32:0] r_range;
    logic r_sat, r_zero;
    logic signed [31:0] r_res;
    logic [1:0] r_status;
    logic signed [DW-1:0] r_mean;
    logic signed [DW-1:0] w_num, w_den;
    logic w_start, w_done;
    logic signed [DW-1:0] w_quot;
    logic [CIW-1:0] w_col;
    logic [AW-1:0]  w_addr;
    logic w_in_ok;
    logic signed [SUM_W:0] w_sum;
    logic signed [DW-1:0] w_mean_s;
    logic w_mean_sat;

    assign w_in_ok = (32'(i_in.row_index) < 32'(MAX_ROWS)) &&
                     (32'(i_in.col_index) < 32'(MAX_COLS));
    assign w_col = CIW'(r_in.col_index);
    assign w_addr = AW'(32'(r_in.row_index) * 32'(MAX_COLS) + 32'(r_in.col_index));
    assign w_sum = SUM_W'(r_sum[w_col]) + (SUM_W+1)'(r_in.value);

    // divider operands: column sum over count for the mean, then scaled offset over range
    always_comb begin
        if (i_ctrl.prep2) begin
            w_num = DW'($signed(33'(r_elem) - 33'($signed(w_mean_s[31:0])))) <<< 16;
            w_den = DW'(r_range);
        end else begin
            w_num = DW'(r_sum[w_col]);
            w_den = DW'($signed({1'b0, r_cnt[w_col]}));
        end
    end

    always_comb begin
        w_mean_sat = 1'b0;
        w_mean_s = r_mean;
        if (r_mean > 64'sd2147483647) begin
            w_mean_s = 64'sd2147483647; w_mean_sat = 1'b1;
        end else if (r_mean < -64'sd2147483648) begin
            w_mean_s = -64'sd2147483648; w_mean_sat = 1'b1;
        end
    end

    assign w_start = i_ctrl.div_start;
    cmrs_div #(.W(DW)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_start),
        .i_num(w_num), .i_den(w_den),
        .o_done(w_done), .o_quot(w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (i_ctrl.capture) begin
            r_in <= i_in;
            r_inside <= w_in_ok;
        end
        if (i_ctrl.fetch) begin
            r_elem <= r_mem[w_addr];
            r_range <= 33'(r_max[w_col]) - 33'(r_min[w_col]);
            r_zero <= (33'(r_max[w_col]) - 33'(r_min[w_col])) <= 0;
            r_sat <= 1'b0;
        end
        if (i_ctrl.prep2) r_sat <= w_mean_sat;
        if (i_ctrl.finish) begin
            if (!r_inside) begin
                r_res <= '0; r_status <= ST_OK;
            end else if (r_zero) begin
                r_res <= '0; r_status <= ST_ZERO;
            end else if (w_quot > 64'sd2147483647) begin
                r_res <= 32'h7FFF_FFFF; r_status <= ST_SAT;
            end else if (w_quot < -64'sd2147483648) begin
                r_res <= 32'h8000_0000; r_status <= ST_SAT;
            end else begin
                r_res <= w_quot[31:0]; r_status <= r_sat ? ST_SAT : ST_OK;
            end
        end
    end

    // mean capture: first quotient of a read, count zero keeps mean at zero
    logic r_div1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_div1 <= 1'b0;
        else if (i_ctrl.fetch) r_div1 <= 1'b1;
        else if (i_ctrl.prep2) r_div1 <= 1'b0;
    end
    always_ff @(posedge i_clk) begin
        if (i_ctrl.fetch) r_mean <= '0;
        else if (w_done && r_div1 && r_cnt[w_col] != '0) r_mean <= w_quot;
    end

    // element memory
    always_ff @(posedge i_clk) begin
        if (i_ctrl.fetch && r_in.cmd == CMD_LOAD && r_inside) r_mem[w_addr] <= r_in.value;
    end

    // column statistics
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_ctrl.fetch && r_in.cmd == CMD_CLEAR)) begin
            for (int c = 0; c < MAX_COLS; c++) begin
                r_sum[c] <= '0;
                r_cnt[c] <= '0;
                r_min[c] <= 32'h7FFF_FFFF;
                r_max[c] <= 32'h8000_0000;
            end
        end else if (i_ctrl.fetch && r_in.cmd == CMD_LOAD && r_inside) begin
            if (r_in.value < r_min[w_col]) r_min[w_col] <= r_in.value;
            if (r_in.value > r_max[w_col]) r_max[w_col] <= r_in.value;
            if (r_in.value != MISSING_MARK) begin
                if (w_sum[SUM_W] != w_sum[SUM_W-1])
                    r_sum[w_col] <= w_sum[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                                 : {1'b0, {(SUM_W-1){1'b1}}};
                else
                    r_sum[w_col] <= w_sum[SUM_W-1:0];
                if (r_cnt[w_col] != '1) r_cnt[w_col] <= r_cnt[w_col] + 1'b1;
            end
        end
    end

    assign o_stat.is_read = (r_in.cmd == CMD_READ);
    assign o_stat.div_done = w_done;
    assign o_stat.skip_div = !r_inside ||
        ((33'(r_max[w_col]) - 33'(r_min[w_col])) <= 0);
    assign o_out.scaled_value = r_res;
    assign o_out.status = r_status;
endmodule

### design/column_mean_range_scaler_top.sv
// top level of the column mean range scaler
// load and clear beats: capture, then memory and statistics update
// a read beat: two 64-step radix-2 divisions in one shared
// divider (mean, then scaling) plus fetch and finish; result held until taken
// one beat at a time; out-of-range or zero-range reads skip both divisions
// synchronous active-low reset clears statistics; element memory is not cleared
module column_mean_range_scaler_top import cmrs_pkg::*; #(
    parameter int MAX_ROWS = MAX_ROWS_DEF,
    parameter int MAX_COLS = MAX_COLS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_out o_data
);
    t_ctrl w_ctrl;   // commands from the controller
    t_stat w_stat;   // status back from the datapath

    // sequencer for one beat at a time
    cmrs_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_valid), .o_in_ready(o_ready),
        .o_out_valid(o_valid), .i_out_ready(i_ready),
        .i_stat(w_stat), .o_ctrl(w_ctrl)
    );

    // memory, statistics and divider
    cmrs_dp #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in(i_data), .i_ctrl(w_ctrl),
        .o_stat(w_stat), .o_out(o_data)
    );
endmodule
